@@ hw/rtl/nsfb_pkg.sv @@
// Package with the shared types and constants of the scaled blit address generator.
package nsfb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int EDGE_W  = 14;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 14;
  localparam int N_CELLS = POS_W;

  localparam logic [CFG_AW-1:0] REG_DEST_WIDTH    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DEST_HEIGHT   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RECT_LEFT     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RECT_BOTTOM   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RECT_WIDTH    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_RECT_HEIGHT   = 3'd7;

  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic             write;
    logic [POS_W-1:0] src_col;
    logic [POS_W-1:0] src_row;
    logic [POS_W-1:0] dst_col;
    logic [POS_W-1:0] dst_row;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]         dest_width;
    logic [DIM_W-1:0]         dest_height;
    logic [DIM_W-1:0]         source_width;
    logic [DIM_W-1:0]         source_height;
    logic signed [EDGE_W-1:0] rect_left;
    logic signed [EDGE_W-1:0] rect_bottom;
    logic [DIM_W-1:0]         rect_width;
    logic [DIM_W-1:0]         rect_height;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] rem_x;
    logic [POS_W-1:0] low_x;
    logic [POS_W-1:0] quo_x;
    logic [DIM_W-1:0] rem_y;
    logic [POS_W-1:0] low_y;
    logic [POS_W-1:0] quo_y;
    logic             pass;
    logic [POS_W-1:0] dst_col;
    logic [POS_W-1:0] dst_row;
  } cell_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DW-1:0] v);
    logic [DIM_W-1:0] d;
    d = v[DIM_W-1:0];
    return (d > DIM_LIMIT) ? DIM_LIMIT : d;
  endfunction

endpackage

@@ hw/rtl/nearest_scaled_flipped_blit.sv @@
// Top level of the nearest-neighbor scaled, flipped blit address generator.
// Pipeline: each item is registered through a front stage, 12 division cells and an
// output stage.
// Throughput: one item per cycle; busy is always low and results cannot be stalled.
// Reset: synchronous active-low reset clears all valid bits and loads the
// register reset values; items in flight are dropped.
module nearest_scaled_flipped_blit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  nsfb_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output nsfb_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [nsfb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [nsfb_pkg::CFG_DW-1:0] cfg_wdata
);
  import nsfb_pkg::*;

  localparam int PROD_W = POS_W + DIM_W;
  localparam int SPAN_W = EDGE_W + 1;

  cfg_t cfg;

  logic                    front_valid_r;
  cell_t                   front_r;
  cell_t                   front_nxt;
  logic [PROD_W-1:0]       prod_x;
  logic [PROD_W-1:0]       prod_y;
  logic signed [SPAN_W-1:0] dx;
  logic signed [SPAN_W-1:0] dy;
  logic                    in_rect;
  logic                    dst_ok;

  logic                    chain_valid [0:N_CELLS];
  cell_t                   chain       [0:N_CELLS];

  logic                    out_valid_r;
  out_item_t               out_data_r;
  out_item_t               out_nxt;
  cell_t                   last;
  logic                    src_ok;
  logic [DIM_W-1:0]        sy;

  nsfb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  always_comb begin
    prod_x  = PROD_W'(in_data.col) * PROD_W'(cfg.source_width);
    prod_y  = PROD_W'(in_data.row) * PROD_W'(cfg.source_height);
    in_rect = ({1'b0, in_data.col} < cfg.rect_width) &&
              ({1'b0, in_data.row} < cfg.rect_height);
    dx = SPAN_W'(cfg.rect_left) + $signed({{(SPAN_W-POS_W){1'b0}}, in_data.col});
    dy = $signed({{(SPAN_W-DIM_W){1'b0}}, cfg.dest_height}) - SPAN_W'(1)
         - SPAN_W'(cfg.rect_bottom) - $signed({{(SPAN_W-POS_W){1'b0}}, in_data.row});
    dst_ok = !dx[SPAN_W-1] && (dx[SPAN_W-2:0] < {1'b0, cfg.dest_width}) &&
             !dy[SPAN_W-1] && (dy[SPAN_W-2:0] < {1'b0, cfg.dest_height});

    front_nxt.rem_x   = prod_x[PROD_W-1:POS_W];
    front_nxt.low_x   = prod_x[POS_W-1:0];
    front_nxt.quo_x   = '0;
    front_nxt.rem_y   = prod_y[PROD_W-1:POS_W];
    front_nxt.low_y   = prod_y[POS_W-1:0];
    front_nxt.quo_y   = '0;
    front_nxt.pass    = in_rect && dst_ok;
    front_nxt.dst_col = dx[POS_W-1:0];
    front_nxt.dst_row = dy[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
  end

  assign chain_valid[0] = front_valid_r;
  assign chain[0]       = front_r;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    nsfb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .div_x     (cfg.rect_width),
      .div_y     (cfg.rect_height),
      .valid_in  (chain_valid[i]),
      .cell_in   (chain[i]),
      .valid_out (chain_valid[i+1]),
      .cell_out  (chain[i+1])
    );
  end

  always_comb begin
    last   = chain[N_CELLS];
    src_ok = ({1'b0, last.quo_x} < cfg.source_width) &&
             ({1'b0, last.quo_y} < cfg.source_height);
    sy     = cfg.source_height - DIM_W'(1) - {1'b0, last.quo_y};
    out_nxt = '0;
    if (last.pass && src_ok) begin
      out_nxt.write   = 1'b1;
      out_nxt.src_col = last.quo_x;
      out_nxt.src_row = sy[POS_W-1:0];
      out_nxt.dst_col = last.dst_col;
      out_nxt.dst_row = last.dst_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_valid[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/nsfb_cfg.sv @@
// Configuration register file of the scaled blit address generator.
module nsfb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nsfb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [nsfb_pkg::CFG_DW-1:0] cfg_wdata,
  output nsfb_pkg::cfg_t              cfg
);
  import nsfb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEST_WIDTH:    cfg_nxt.dest_width    = sat_dim(cfg_wdata);
        REG_DEST_HEIGHT:   cfg_nxt.dest_height   = sat_dim(cfg_wdata);
        REG_SOURCE_WIDTH:  cfg_nxt.source_width  = sat_dim(cfg_wdata);
        REG_SOURCE_HEIGHT: cfg_nxt.source_height = sat_dim(cfg_wdata);
        REG_RECT_LEFT:     cfg_nxt.rect_left     = $signed(cfg_wdata[EDGE_W-1:0]);
        REG_RECT_BOTTOM:   cfg_nxt.rect_bottom   = $signed(cfg_wdata[EDGE_W-1:0]);
        REG_RECT_WIDTH:    cfg_nxt.rect_width    = cfg_wdata[DIM_W-1:0];
        REG_RECT_HEIGHT:   cfg_nxt.rect_height   = cfg_wdata[DIM_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      cfg_r.rect_width  <= DIM_W'(1);
      cfg_r.rect_height <= DIM_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/nsfb_cell.sv @@
// One restoring division step for the column and row quotients, with item sideband.
module nsfb_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [nsfb_pkg::DIM_W-1:0] div_x,
  input  logic [nsfb_pkg::DIM_W-1:0] div_y,
  input  logic                       valid_in,
  input  nsfb_pkg::cell_t            cell_in,
  output logic                       valid_out,
  output nsfb_pkg::cell_t            cell_out
);
  import nsfb_pkg::*;

  logic             valid_r;
  cell_t            cell_r;
  cell_t            cell_nxt;
  logic [DIM_W:0]   trial_x;
  logic [DIM_W:0]   trial_y;
  logic [DIM_W:0]   diff_x;
  logic [DIM_W:0]   diff_y;
  logic             take_x;
  logic             take_y;

  always_comb begin
    trial_x = {cell_in.rem_x, cell_in.low_x[POS_W-1]};
    trial_y = {cell_in.rem_y, cell_in.low_y[POS_W-1]};
    diff_x  = trial_x - {1'b0, div_x};
    diff_y  = trial_y - {1'b0, div_y};
    take_x  = trial_x >= {1'b0, div_x};
    take_y  = trial_y >= {1'b0, div_y};

    cell_nxt       = cell_in;
    cell_nxt.rem_x = take_x ? diff_x[DIM_W-1:0] : trial_x[DIM_W-1:0];
    cell_nxt.rem_y = take_y ? diff_y[DIM_W-1:0] : trial_y[DIM_W-1:0];
    cell_nxt.low_x = {cell_in.low_x[POS_W-2:0], 1'b0};
    cell_nxt.low_y = {cell_in.low_y[POS_W-2:0], 1'b0};
    cell_nxt.quo_x = {cell_in.quo_x[POS_W-2:0], take_x};
    cell_nxt.quo_y = {cell_in.quo_y[POS_W-2:0], take_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign valid_out = valid_r;
  assign cell_out  = cell_r;

endmodule
